// File: hdl/shn_pkg.sv
// shared types, codes and constants of the spatial hash neighbour finder
`default_nettype none

package shn_pkg;

    // default sizes
    localparam int GRID_SIDE_DEF = 256;
    localparam int MAX_CELLS_DEF = 4096;

    // field widths
    localparam int IDX_W = 12;
    localparam int XY_W  = 8;
    localparam int LVL_W = 4;
    localparam int ML_W  = 4;
    localparam int MS_W  = 9;
    localparam int NB_W  = 13;
    localparam int KIND_W = 2;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = MS_W;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_SIDE = 1'b1;

    // request codes on the input stream
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // command queue
    localparam int Q_DEPTH = 4;

    // coordinate slots of a queued command
    localparam int NSLOT   = 6;
    localparam int SLOT_X0 = 0;
    localparam int SLOT_X1 = 1;
    localparam int SLOT_Y0 = 2;
    localparam int SLOT_Y1 = 3;
    localparam int SLOT_XL = 0;
    localparam int SLOT_XM = 1;
    localparam int SLOT_XR = 2;
    localparam int SLOT_YB = 3;
    localparam int SLOT_YM = 4;
    localparam int SLOT_YT = 5;

    typedef enum logic [KIND_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_PAINT = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic init_busy;
        logic idle;
    } back_status_t;

endpackage

`default_nettype wire

// File: hdl/shn_front.sv
// front end: decodes a request into a store command with clipped fine-grid coordinates
`default_nettype none

module shn_front
    import shn_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    parameter int MAX_CELLS = MAX_CELLS_DEF
)
(
    input  wire logic [ML_W-1:0]              max_level,
    input  wire logic [MS_W-1:0]              coarse_side,
    input  wire logic [1:0]                   req_type,
    input  wire logic [IDX_W-1:0]             cell_index,
    input  wire logic [XY_W-1:0]              cell_x,
    input  wire logic [XY_W-1:0]              cell_y,
    input  wire logic [LVL_W-1:0]             cell_level,
    output logic                              cmd_ok,
    output cmd_kind_t                         cmd_kind,
    output logic [NSLOT-1:0][$clog2(GRID_SIDE+1)-1:0] cmd_coord
);

    localparam int CW1 = $clog2(GRID_SIDE + 1);
    // wide enough for coarse_side or cell_x + 1 shifted by up to fifteen places
    localparam int SW = 24;
    localparam logic [SW-1:0] GS_W = SW'(GRID_SIDE);
    localparam logic [16:0] MC_W = 17'(MAX_CELLS);

    function automatic logic [SW-1:0] umin(input logic [SW-1:0] a, input logic [SW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    logic [LVL_W-1:0] lev;
    logic [ML_W-1:0]  sh;
    logic [SW-1:0]    side_raw;
    logic [SW-1:0]    side;
    logic [SW-1:0]    side_m1;
    logic [SW-1:0]    x0;
    logic [SW-1:0]    y0;
    logic [SW-1:0]    x1;
    logic [SW-1:0]    y1;

    always_comb
    begin
        lev      = (cell_level > max_level) ? max_level : cell_level;
        sh       = max_level - lev;
        side_raw = SW'(coarse_side) << max_level;
        if (side_raw == '0)
        begin
            side = SW'(1);
        end
        else
        begin
            side = umin(side_raw, GS_W);
        end
        side_m1 = side - SW'(1);
        x0 = SW'(cell_x) << sh;
        y0 = SW'(cell_y) << sh;
        x1 = SW'({1'b0, cell_x} + 9'd1) << sh;
        y1 = SW'({1'b0, cell_y} + 9'd1) << sh;
    end

    always_comb
    begin
        cmd_ok    = 1'b0;
        cmd_kind  = CMD_CLEAR;
        cmd_coord = '0;
        unique case (req_type)
            REQ_CLEAR:
            begin
                cmd_ok   = 1'b1;
                cmd_kind = CMD_CLEAR;
            end
            REQ_INSERT:
            begin
                cmd_ok   = ({5'd0, cell_index} < MC_W);
                cmd_kind = CMD_PAINT;
                // square clipped to the grid, empty when the origin is outside
                cmd_coord[SLOT_X0] = CW1'(umin(x0, side));
                cmd_coord[SLOT_X1] = CW1'(umin(x1, side));
                cmd_coord[SLOT_Y0] = CW1'(umin(y0, side));
                cmd_coord[SLOT_Y1] = CW1'(umin(y1, side));
            end
            REQ_QUERY:
            begin
                cmd_ok   = 1'b1;
                cmd_kind = CMD_QUERY;
                cmd_coord[SLOT_XL] = (x0 == '0) ? '0 : CW1'(umin(x0 - SW'(1), side_m1));
                cmd_coord[SLOT_XM] = CW1'(umin(x0, side_m1));
                cmd_coord[SLOT_XR] = CW1'(umin(x1, side_m1));
                cmd_coord[SLOT_YB] = (y0 == '0) ? '0 : CW1'(umin(y0 - SW'(1), side_m1));
                cmd_coord[SLOT_YM] = CW1'(umin(y0, side_m1));
                cmd_coord[SLOT_YT] = CW1'(umin(y1, side_m1));
            end
            default:
            begin
                // unused request code is dropped
                cmd_ok = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/shn_queue.sv
// short command queue between front and back end
`default_nettype none

module shn_queue
    import shn_pkg::*;
#(
    parameter int W = 8
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [W-1:0]  din,
    input  wire logic          pop,
    output logic [W-1:0]       dout,
    output queue_status_t      stat
);

    localparam int QAW = $clog2(Q_DEPTH);

    logic [W-1:0]   slot_reg [Q_DEPTH];
    logic [QAW-1:0] wp_reg;
    logic [QAW-1:0] wp_next;
    logic [QAW-1:0] rp_reg;
    logic [QAW-1:0] rp_next;
    logic [QAW:0]   count_reg;
    logic [QAW:0]   count_next;

    always_comb
    begin
        wp_next    = push ? wp_reg + 1'b1 : wp_reg;
        rp_next    = pop ? rp_reg + 1'b1 : rp_reg;
        count_next = count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= din;
        end
    end

    assign dout       = slot_reg[rp_reg];
    assign stat.full  = (count_reg == (QAW+1)'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

// File: hdl/shn_back.sv
// back end: fine-grid store with clearing sweep, square painter and neighbour reads
`default_nettype none

module shn_back
    import shn_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire cmd_kind_t                            cmd_kind,
    input  wire logic [IDX_W-1:0]                     cmd_idx,
    input  wire logic [NSLOT-1:0][$clog2(GRID_SIDE+1)-1:0] cmd_coord,
    input  wire queue_status_t                        q_stat,
    output logic                                      pop,
    output back_status_t                              b_stat,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [4*NB_W-1:0]                         m_data
);

    localparam int CW1   = $clog2(GRID_SIDE + 1);
    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SWEEP = 6'b000010,
        ST_PAINT = 6'b000100,
        ST_QREAD = 6'b001000,
        ST_QLAST = 6'b010000,
        ST_QHOLD = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   init_reg;
    logic   init_next;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;
    logic [1:0]    qcnt_reg;
    logic [1:0]    qcnt_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    logic [CW1-1:0] px_reg;
    logic [CW1-1:0] px_next;
    logic [CW1-1:0] py_reg;
    logic [CW1-1:0] py_next;
    logic [NSLOT-1:0][CW1-1:0] coord_reg;
    logic [NSLOT-1:0][CW1-1:0] coord_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [3:0][NB_W-1:0] acc_reg;
    logic [3:0][NB_W-1:0] acc_next;
    logic [3:0][NB_W-1:0] out_data_reg;
    logic [3:0][NB_W-1:0] out_data_next;

    logic [NB_W-1:0] store_mem [DEPTH];
    logic [NB_W-1:0] rd_data_reg;
    logic            mem_we;
    logic            sweep;
    logic [CW1-1:0]  mx;
    logic [CW1-1:0]  my;
    logic [AW-1:0]   mem_addr;
    logic [NB_W-1:0] mem_wdata;

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        cnt_next       = cnt_reg;
        qcnt_next      = qcnt_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        coord_next     = coord_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        sweep          = 1'b0;
        mx             = px_reg;
        my             = py_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_SWEEP:
            begin
                mem_we = 1'b1;
                sweep  = 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    init_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    coord_next = cmd_coord;
                    idx_next   = cmd_idx;
                    unique case (cmd_kind)
                        CMD_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = ST_SWEEP;
                        end
                        CMD_PAINT:
                        begin
                            px_next = cmd_coord[SLOT_X0];
                            py_next = cmd_coord[SLOT_Y0];
                            if ((cmd_coord[SLOT_X0] < cmd_coord[SLOT_X1]) &&
                                (cmd_coord[SLOT_Y0] < cmd_coord[SLOT_Y1]))
                            begin
                                state_next = ST_PAINT;
                            end
                        end
                        CMD_QUERY:
                        begin
                            qcnt_next  = '0;
                            state_next = ST_QREAD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PAINT:
            begin
                mem_we = 1'b1;
                if ((px_reg + 1'b1) == coord_reg[SLOT_X1])
                begin
                    px_next = coord_reg[SLOT_X0];
                    if ((py_reg + 1'b1) == coord_reg[SLOT_Y1])
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        py_next = py_reg + 1'b1;
                    end
                end
                else
                begin
                    px_next = px_reg + 1'b1;
                end
            end
            ST_QREAD:
            begin
                // probe order: left, right, bottom, top
                unique case (qcnt_reg)
                    2'd0:
                    begin
                        mx = coord_reg[SLOT_XL];
                        my = coord_reg[SLOT_YM];
                    end
                    2'd1:
                    begin
                        mx = coord_reg[SLOT_XR];
                        my = coord_reg[SLOT_YM];
                    end
                    2'd2:
                    begin
                        mx = coord_reg[SLOT_XM];
                        my = coord_reg[SLOT_YB];
                    end
                    default:
                    begin
                        mx = coord_reg[SLOT_XM];
                        my = coord_reg[SLOT_YT];
                    end
                endcase
                // read data arrives in the cycle after its address
                if (qcnt_reg != 2'd0)
                begin
                    acc_next[qcnt_reg - 2'd1] = rd_data_reg;
                end
                qcnt_next = qcnt_reg + 2'd1;
                if (qcnt_reg == 2'd3)
                begin
                    state_next = ST_QLAST;
                end
            end
            ST_QLAST:
            begin
                acc_next[3] = rd_data_reg;
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = {rd_data_reg, acc_reg[2], acc_reg[1], acc_reg[0]};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_QHOLD;
                end
            end
            ST_QHOLD:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mem_addr  = sweep ? cnt_reg : AW'(32'(my) * GRID_SIDE + 32'(mx));
    assign mem_wdata = sweep ? {NB_W{1'b1}} : {1'b0, idx_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= store_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            init_reg      <= 1'b1;
            cnt_reg       <= '0;
            qcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            cnt_reg       <= cnt_next;
            qcnt_reg      <= qcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        coord_reg    <= coord_next;
        idx_reg      <= idx_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign b_stat.init_busy = init_reg;
    assign b_stat.idle      = (state_reg == ST_IDLE);
    assign m_tvalid         = out_valid_reg;
    assign m_data           = out_data_reg;

endmodule

`default_nettype wire

// File: hdl/amr_spatial_hash_neighbors.sv
// top level of the adaptive-mesh face neighbour finder on a fine-grid spatial hash
//
//   channel   direction  width        contents
//   s_axis    in         tuser 2      request kind (clear, insert, query)
//                        tdata 32     cell index, column, row, level
//   m_axis    out        tdata 56     left, right, bottom, top neighbour (13 bits each)
//   cfg       in         idx 1, 9     max_level, coarse_side
//
// a query holds the back end while it takes the command from the queue, makes four
// reads of the single-port store and hands the result over; an insert writes each
// painted fine entry in turn, a clear every store entry in turn
// after reset the store is swept to empty; s_tready is low until the sweep ends,
// configuration writes are taken throughout
// a four-entry command queue lets the input side run ahead; s_tready drops while it is full
// and a finished query waits in the back end while the output register is occupied
`default_nettype none

module amr_spatial_hash_neighbors
    import shn_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    parameter int MAX_CELLS = MAX_CELLS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [11:0] cell_index, [19:12] cell_x, [27:20] cell_y, [31:28] cell_level
    input  wire logic [31:0]           s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [12:0] left, [25:13] right, [38:26] bottom, [51:39] top neighbour, [55:52] zero
    output logic [55:0]                m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW1 = $clog2(GRID_SIDE + 1);
    localparam int QW  = KIND_W + IDX_W + NSLOT * CW1;

    logic [ML_W-1:0] max_level_reg;
    logic [ML_W-1:0] max_level_next;
    logic [MS_W-1:0] coarse_side_reg;
    logic [MS_W-1:0] coarse_side_next;

    logic                      f_ok;
    cmd_kind_t                 f_kind;
    logic [NSLOT-1:0][CW1-1:0] f_coord;
    logic                      q_push;
    logic                      q_pop;
    logic [QW-1:0]             q_dout;
    queue_status_t             q_stat;
    back_status_t              b_stat;
    logic [4*NB_W-1:0]         b_data;

    always_comb
    begin
        max_level_next   = max_level_reg;
        coarse_side_next = coarse_side_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_LEVEL:   max_level_next   = cfg_data[ML_W-1:0];
                REG_COARSE_SIDE: coarse_side_next = cfg_data[MS_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg   <= '0;
            coarse_side_reg <= MS_W'(1);
        end
        else
        begin
            max_level_reg   <= max_level_next;
            coarse_side_reg <= coarse_side_next;
        end
    end

    shn_front #(
        .GRID_SIDE (GRID_SIDE),
        .MAX_CELLS (MAX_CELLS)
    ) u_front (
        .max_level   (max_level_reg),
        .coarse_side (coarse_side_reg),
        .req_type    (s_tuser),
        .cell_index  (s_tdata[11:0]),
        .cell_x      (s_tdata[19:12]),
        .cell_y      (s_tdata[27:20]),
        .cell_level  (s_tdata[31:28]),
        .cmd_ok      (f_ok),
        .cmd_kind    (f_kind),
        .cmd_coord   (f_coord)
    );

    assign s_tready = !q_stat.full && !b_stat.init_busy;
    // dropped requests are taken but never queued
    assign q_push   = s_tvalid && s_tready && f_ok;

    shn_queue #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   ({f_kind, s_tdata[11:0], f_coord}),
        .pop   (q_pop),
        .dout  (q_dout),
        .stat  (q_stat)
    );

    shn_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_kind  (cmd_kind_t'(q_dout[QW-1 -: KIND_W])),
        .cmd_idx   (q_dout[NSLOT*CW1 +: IDX_W]),
        .cmd_coord (q_dout[NSLOT*CW1-1:0]),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .b_stat    (b_stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_data    (b_data)
    );

    assign m_tdata = {4'd0, b_data};

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty && b_stat.idle)
        else $error("command popped while queue empty or back end busy");

    a_init_queue_empty: assert property (@(posedge clk) disable iff (!rst_n)
        b_stat.init_busy |-> q_stat.empty)
        else $error("command queued during the power-up sweep");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(b_stat.init_busy) |-> !m_tvalid)
        else $error("result presented before the store was initialised");

endmodule

`default_nettype wire
